>>> rtl/core/sled_pkg.sv
// Package with the phase codes, register indexes and helpers of the status LED sequencer.
package sled_pkg;

	// Phase of the blink pattern as reported on each result.
	typedef enum logic [2:0] {
		PH_STARTUP  = 3'd0,
		PH_IDLE     = 3'd1,
		PH_INVERT   = 3'd2,
		PH_GAP      = 3'd3,
		PH_PAUSE    = 3'd4,
		PH_DISABLED = 3'd5
	} phase_t;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_LED_ENABLED   = 3'd0,
		REG_ACTIVE_LEVEL  = 3'd1,
		REG_BLINK_LIT     = 3'd2,
		REG_BLINK_GAP     = 3'd3,
		REG_GROUP_PAUSE   = 3'd4,
		REG_IDLE_HOLD     = 3'd5,
		REG_STARTUP_LIT   = 3'd6,
		REG_STARTUP_DARK  = 3'd7
	} reg_index_t;

	localparam int unsigned DurW = 16;
	localparam int unsigned CountW = 8;
	localparam int unsigned StartW = 4;

	// Reset values of the duration registers, in ticks.
	localparam logic [DurW-1:0] BlinkLitReset    = 16'd180;
	localparam logic [DurW-1:0] BlinkGapReset    = 16'd220;
	localparam logic [DurW-1:0] GroupPauseReset  = 16'd1200;
	localparam logic [DurW-1:0] IdleHoldReset    = 16'd1000;
	localparam logic [DurW-1:0] StartupLitReset  = 16'd40;
	localparam logic [DurW-1:0] StartupDarkReset = 16'd60;

	// A segment length of zero is played as one tick.
	function automatic logic [DurW-1:0] seg_len(input logic [DurW-1:0] v);
		seg_len = (v == '0) ? {{(DurW-1){1'b0}}, 1'b1} : v;
	endfunction

endpackage

>>> rtl/core/status_led_blink_code_sequencer_top.sv
// Top level of the status LED blink-code sequencer.
// Each request is one millisecond tick carrying the upstream link flag and the client
// count; every request yields exactly one result with the pin level, the drive enable,
// the logical LED state and the current phase. The segment counter update and the
// next-segment selection sit between the state registers and a result register, so
// one request is taken per clock while the result register is empty or being emptied,
// and its result is valid on the following cycle. After reset the block plays the low
// four bits of STARTUP_BLINKS as a count of lit/dark blinks, then repeats the client
// blink code. Configuration writes are always accepted. Enable and polarity apply from
// the next tick; a new segment length takes effect when the next segment loads.
module status_led_blink_code_sequencer_top #(
	parameter int unsigned STARTUP_BLINKS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write channel.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// Tick request channel.
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        link_up,
	input  logic [7:0]  num_clients,
	// Result channel.
	output logic        out_valid,
	input  logic        out_ready,
	output logic        pin_level,
	output logic        pin_driven,
	output logic        led_lit,
	output logic [2:0]  phase
);

	localparam logic [sled_pkg::StartW-1:0] StartCount = STARTUP_BLINKS[sled_pkg::StartW-1:0];
	localparam logic HasStartup = (StartCount != '0);

	// Configuration registers.
	logic                      led_enabled_q;
	logic                      active_level_q;
	logic [sled_pkg::DurW-1:0] blink_lit_q;
	logic [sled_pkg::DurW-1:0] blink_gap_q;
	logic [sled_pkg::DurW-1:0] group_pause_q;
	logic [sled_pkg::DurW-1:0] idle_hold_q;
	logic [sled_pkg::DurW-1:0] startup_lit_q;
	logic [sled_pkg::DurW-1:0] startup_dark_q;

	// Pattern state.
	sled_pkg::phase_t            phase_q, phase_d;
	logic [sled_pkg::DurW-1:0]   dur_q, dur_d;
	logic [sled_pkg::CountW-1:0] blinks_q, blinks_d;
	logic [sled_pkg::StartW-1:0] start_q, start_d;
	logic                        base_q, base_d;
	logic                        lit_q, lit_d;

	// Result register.
	logic             out_valid_q;
	logic             pin_level_q;
	logic             pin_driven_q;
	logic             led_lit_q;
	sled_pkg::phase_t phase_out_q;

	logic accept;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_enabled_q  <= 1'b1;
			active_level_q <= 1'b1;
			blink_lit_q    <= sled_pkg::BlinkLitReset;
			blink_gap_q    <= sled_pkg::BlinkGapReset;
			group_pause_q  <= sled_pkg::GroupPauseReset;
			idle_hold_q    <= sled_pkg::IdleHoldReset;
			startup_lit_q  <= sled_pkg::StartupLitReset;
			startup_dark_q <= sled_pkg::StartupDarkReset;
		end else if (cfg_valid && cfg_ready) begin
			case (sled_pkg::reg_index_t'(cfg_index))
				sled_pkg::REG_LED_ENABLED:  led_enabled_q  <= cfg_data[0];
				sled_pkg::REG_ACTIVE_LEVEL: active_level_q <= cfg_data[0];
				sled_pkg::REG_BLINK_LIT:    blink_lit_q    <= cfg_data;
				sled_pkg::REG_BLINK_GAP:    blink_gap_q    <= cfg_data;
				sled_pkg::REG_GROUP_PAUSE:  group_pause_q  <= cfg_data;
				sled_pkg::REG_IDLE_HOLD:    idle_hold_q    <= cfg_data;
				sled_pkg::REG_STARTUP_LIT:  startup_lit_q  <= cfg_data;
				sled_pkg::REG_STARTUP_DARK: startup_dark_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Next pattern state: load a new segment when the current one has run out,
	// then count one tick off it.
	always_comb begin
		logic [sled_pkg::DurW-1:0]   dur_eff;
		logic [sled_pkg::CountW-1:0] blinks_dec;
		logic [sled_pkg::StartW-1:0] start_dec;
		logic                        new_cycle;
		logic                        up_base;

		phase_d    = phase_q;
		dur_d      = dur_q;
		blinks_d   = blinks_q;
		start_d    = start_q;
		base_d     = base_q;
		lit_d      = lit_q;
		dur_eff    = dur_q;
		new_cycle  = 1'b0;
		blinks_dec = (blinks_q != '0) ? blinks_q - 1'b1 : blinks_q;
		start_dec  = (start_q != '0) ? start_q - 1'b1 : start_q;
		up_base    = !link_up;

		if (dur_q == '0) begin
			case (phase_q)
				sled_pkg::PH_STARTUP: begin
					if (lit_q) begin
						lit_d   = 1'b0;
						dur_eff = sled_pkg::seg_len(startup_dark_q);
					end else begin
						start_d = start_dec;
						if (start_dec != '0) begin
							lit_d   = 1'b1;
							dur_eff = sled_pkg::seg_len(startup_lit_q);
						end else begin
							new_cycle = 1'b1;
						end
					end
				end
				sled_pkg::PH_INVERT: begin
					phase_d = sled_pkg::PH_GAP;
					lit_d   = base_q;
					dur_eff = sled_pkg::seg_len(blink_gap_q);
				end
				sled_pkg::PH_GAP: begin
					blinks_d = blinks_dec;
					lit_d    = base_q;
					if (blinks_dec != '0) begin
						phase_d = sled_pkg::PH_INVERT;
						lit_d   = !base_q;
						dur_eff = sled_pkg::seg_len(blink_lit_q);
					end else begin
						phase_d = sled_pkg::PH_PAUSE;
						dur_eff = sled_pkg::seg_len(group_pause_q);
					end
				end
				default: begin
					new_cycle = 1'b1;
				end
			endcase
		end

		// Start of a cycle samples the link flag and client count.
		if (new_cycle) begin
			base_d = up_base;
			if (num_clients == '0) begin
				phase_d = sled_pkg::PH_IDLE;
				lit_d   = up_base;
				dur_eff = sled_pkg::seg_len(idle_hold_q);
			end else begin
				blinks_d = num_clients;
				phase_d  = sled_pkg::PH_INVERT;
				lit_d    = !up_base;
				dur_eff  = sled_pkg::seg_len(blink_lit_q);
			end
		end

		dur_d = dur_eff - 1'b1;
	end

	// Pattern state advances on every accepted tick while enabled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= sled_pkg::PH_STARTUP;
			dur_q    <= HasStartup ? sled_pkg::seg_len(sled_pkg::StartupLitReset) : '0;
			blinks_q <= '0;
			start_q  <= StartCount;
			base_q   <= 1'b0;
			lit_q    <= HasStartup;
		end else if (accept && led_enabled_q) begin
			phase_q  <= phase_d;
			dur_q    <= dur_d;
			blinks_q <= blinks_d;
			start_q  <= start_d;
			base_q   <= base_d;
			lit_q    <= lit_d;
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	// Result payload, formed from the state after the segment load.
	always_ff @(posedge clk) begin
		if (accept) begin
			if (led_enabled_q) begin
				pin_level_q  <= lit_d ? active_level_q : !active_level_q;
				pin_driven_q <= 1'b1;
				led_lit_q    <= lit_d;
				phase_out_q  <= phase_d;
			end else begin
				pin_level_q  <= 1'b0;
				pin_driven_q <= 1'b0;
				led_lit_q    <= 1'b0;
				phase_out_q  <= sled_pkg::PH_DISABLED;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign pin_level  = pin_level_q;
	assign pin_driven = pin_driven_q;
	assign led_lit    = led_lit_q;
	assign phase      = phase_out_q;

endmodule

>>> tb/tb.sv
// Self-checking testbench for the status LED blink-code sequencer.
`timescale 1ns / 100ps

module tb;

	localparam int StartBlinks = 10;
	localparam int CycleLimit = 20000;

	// One result of the sequencer as seen on the output port.
	typedef struct packed {
		logic             pin_level;
		logic             pin_driven;
		logic             led_lit;
		sled_pkg::phase_t phase;
	} tick_result_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic        link_up;
	logic [7:0]  num_clients;
	logic        out_valid;
	logic        out_ready;
	logic        pin_level;
	logic        pin_driven;
	logic        led_lit;
	logic [2:0]  phase;

	// Predicted pattern state.
	sled_pkg::phase_t m_phase;
	logic [15:0]      m_left;
	logic [7:0]       m_blinks;
	logic [3:0]       m_starts;
	logic             m_base;
	logic             m_lit;

	// Register copies.
	logic        c_en;
	logic        c_act;
	logic [15:0] c_blink_lit;
	logic [15:0] c_blink_gap;
	logic [15:0] c_pause;
	logic [15:0] c_hold;
	logic [15:0] c_st_lit;
	logic [15:0] c_st_dark;

	tick_result_t expected_ticks[$];
	tick_result_t want;
	int errors = 0;
	int ticks_sent = 0;
	int results_seen = 0;
	int cycles_begun = 0;
	int reg_writes = 0;
	int cycle_count = 0;
	int in_idle_pct = 0;
	int out_stall_pct = 0;

	status_led_blink_code_sequencer_top #(
		.STARTUP_BLINKS(StartBlinks)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.link_up(link_up),
		.num_clients(num_clients),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.pin_level(pin_level),
		.pin_driven(pin_driven),
		.led_lit(led_lit),
		.phase(phase)
	);

	always #4 clk = ~clk;

	// Cycle counter with a hard stop in case the block hangs.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Receiver back-pressure, changed at the falling edge.
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= out_stall_pct);
	end

	// Compare each accepted result with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (expected_ticks.size() == 0) begin
				$error("result arrived with no request outstanding");
				errors++;
			end else begin
				want = expected_ticks.pop_front();
				if (pin_level !== want.pin_level) begin
					$error("pin_level: expected %0d, got %0d", want.pin_level, pin_level);
					errors++;
				end
				if (pin_driven !== want.pin_driven) begin
					$error("pin_driven: expected %0d, got %0d", want.pin_driven, pin_driven);
					errors++;
				end
				if (led_lit !== want.led_lit) begin
					$error("led_lit: expected %0d, got %0d", want.led_lit, led_lit);
					errors++;
				end
				if (phase !== want.phase) begin
					$error("phase: expected %0d, got %0d", want.phase, phase);
					errors++;
				end
			end
		end
	end

	// A zero-length segment still lasts one tick.
	function automatic logic [15:0] at_least_one(input logic [15:0] v);
		return (v == 16'd0) ? 16'd1 : v;
	endfunction

	function automatic void pattern_reset();
		c_en = 1'b1;
		c_act = 1'b1;
		c_blink_lit = sled_pkg::BlinkLitReset;
		c_blink_gap = sled_pkg::BlinkGapReset;
		c_pause = sled_pkg::GroupPauseReset;
		c_hold = sled_pkg::IdleHoldReset;
		c_st_lit = sled_pkg::StartupLitReset;
		c_st_dark = sled_pkg::StartupDarkReset;
		m_phase = sled_pkg::PH_STARTUP;
		m_blinks = 8'd0;
		m_base = 1'b0;
		m_starts = StartBlinks[3:0];
		if (m_starts != 4'd0) begin
			m_left = at_least_one(c_st_lit);
			m_lit = 1'b1;
		end else begin
			m_left = 16'd0;
			m_lit = 1'b0;
		end
	endfunction

	// Sample the inputs and open a new blink cycle.
	function automatic void begin_blink_cycle(input logic up, input logic [7:0] cnt);
		cycles_begun++;
		m_base = ~up;
		if (cnt == 8'd0) begin
			m_phase = sled_pkg::PH_IDLE;
			m_lit = m_base;
			m_left = at_least_one(c_hold);
		end else begin
			m_blinks = cnt;
			m_phase = sled_pkg::PH_INVERT;
			m_lit = ~m_base;
			m_left = at_least_one(c_blink_lit);
		end
	endfunction

	// Load the segment that follows the one just finished.
	function automatic void load_next_segment(input logic up, input logic [7:0] cnt);
		case (m_phase)
			sled_pkg::PH_STARTUP: begin
				if (m_lit) begin
					m_lit = 1'b0;
					m_left = at_least_one(c_st_dark);
				end else begin
					if (m_starts != 4'd0)
						m_starts--;
					if (m_starts != 4'd0) begin
						m_lit = 1'b1;
						m_left = at_least_one(c_st_lit);
					end else begin
						begin_blink_cycle(up, cnt);
					end
				end
			end
			sled_pkg::PH_INVERT: begin
				m_phase = sled_pkg::PH_GAP;
				m_lit = m_base;
				m_left = at_least_one(c_blink_gap);
			end
			sled_pkg::PH_GAP: begin
				if (m_blinks != 8'd0)
					m_blinks--;
				if (m_blinks != 8'd0) begin
					m_phase = sled_pkg::PH_INVERT;
					m_lit = ~m_base;
					m_left = at_least_one(c_blink_lit);
				end else begin
					m_phase = sled_pkg::PH_PAUSE;
					m_lit = m_base;
					m_left = at_least_one(c_pause);
				end
			end
			default: begin
				begin_blink_cycle(up, cnt);
			end
		endcase
	endfunction

	// Advance the pattern by one tick and queue the result it yields.
	function automatic void predict_led(input logic up, input logic [7:0] cnt);
		tick_result_t r;
		if (!c_en) begin
			r = '{1'b0, 1'b0, 1'b0, sled_pkg::PH_DISABLED};
		end else begin
			if (m_left == 16'd0)
				load_next_segment(up, cnt);
			r.pin_level = m_lit ? c_act : ~c_act;
			r.pin_driven = 1'b1;
			r.led_lit = m_lit;
			r.phase = m_phase;
			if (m_left != 16'd0)
				m_left--;
		end
		expected_ticks.push_back(r);
	endfunction

	// Send one tick request; valid stays up until the request is accepted.
	task automatic send_tick(input logic up, input logic [7:0] cnt);
		@(negedge clk);
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		link_up <= up;
		num_clients <= cnt;
		do @(posedge clk); while (!in_ready);
		predict_led(up, cnt);
		ticks_sent++;
	endtask

	// Stop sending and wait until every result is back.
	task automatic wait_drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_ticks.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input sled_pkg::reg_index_t idx, input logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			sled_pkg::REG_LED_ENABLED:  c_en = val[0];
			sled_pkg::REG_ACTIVE_LEVEL: c_act = val[0];
			sled_pkg::REG_BLINK_LIT:    c_blink_lit = val;
			sled_pkg::REG_BLINK_GAP:    c_blink_gap = val;
			sled_pkg::REG_GROUP_PAUSE:  c_pause = val;
			sled_pkg::REG_IDLE_HOLD:    c_hold = val;
			sled_pkg::REG_STARTUP_LIT:  c_st_lit = val;
			sled_pkg::REG_STARTUP_DARK: c_st_dark = val;
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_timing(input logic [15:0] b_lit, input logic [15:0] b_gap,
			input logic [15:0] pause, input logic [15:0] hold);
		write_reg(sled_pkg::REG_BLINK_LIT, b_lit);
		write_reg(sled_pkg::REG_BLINK_GAP, b_gap);
		write_reg(sled_pkg::REG_GROUP_PAUSE, pause);
		write_reg(sled_pkg::REG_IDLE_HOLD, hold);
	endtask

	// Hold the inputs until n more blink cycles have begun.
	task automatic run_cycles(input logic up, input logic [7:0] cnt, input int n);
		int target;
		target = cycles_begun + n;
		while (cycles_begun < target)
			send_tick(up, cnt);
	endtask

	// Startup blinks from reset, then shortened timing with a zero dark time.
	task automatic test_startup();
		int i;
		for (i = 0; i < 3; i++)
			send_tick(1'b1, 8'd0);
		wait_drain();
		write_reg(sled_pkg::REG_STARTUP_LIT, 16'd1);
		write_reg(sled_pkg::REG_STARTUP_DARK, 16'd0);
		set_timing(16'd2, 16'd1, 16'd3, 16'd2);
		while (m_phase == sled_pkg::PH_STARTUP)
			send_tick(1'($urandom_range(1)), 8'($urandom_range(3)));
	endtask

	// Idle holds and blink groups for both link states.
	task automatic test_blink_groups();
		wait_drain();
		set_timing(16'd2, 16'd1, 16'd3, 16'd2);
		run_cycles(1'b1, 8'd0, 2);
		run_cycles(1'b0, 8'd0, 2);
		run_cycles(1'b1, 8'd1, 2);
		run_cycles(1'b0, 8'd3, 2);
		wait_drain();
		set_timing(16'd1, 16'd1, 16'd1, 16'd1);
		run_cycles(1'b1, 8'd16, 1);
	endtask

	// Inverted pin polarity, then the disabled state and resumption.
	task automatic test_polarity_disable();
		int i;
		wait_drain();
		write_reg(sled_pkg::REG_ACTIVE_LEVEL, 16'd0);
		set_timing(16'd3, 16'd2, 16'd2, 16'd3);
		run_cycles(1'b0, 8'd2, 2);
		run_cycles(1'b1, 8'd0, 1);
		wait_drain();
		write_reg(sled_pkg::REG_LED_ENABLED, 16'd0);
		for (i = 0; i < 6; i++)
			send_tick(1'($urandom_range(1)), 8'($urandom_range(255)));
		wait_drain();
		write_reg(sled_pkg::REG_LED_ENABLED, 16'd1);
		write_reg(sled_pkg::REG_ACTIVE_LEVEL, 16'd1);
		run_cycles(1'b1, 8'd1, 2);
	endtask

	// The largest client count opening a cycle with full-length segments,
	// checked over the first ticks of that cycle.
	task automatic test_long_segment();
		int i;
		wait_drain();
		set_timing(16'd1, 16'd1, 16'd1, 16'd1);
		// Get to the last tick of an idle or pause segment first.
		while (!(m_left == 16'd0 &&
				(m_phase == sled_pkg::PH_IDLE || m_phase == sled_pkg::PH_PAUSE)))
			send_tick(1'($urandom_range(1)), 8'd0);
		wait_drain();
		set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		write_reg(sled_pkg::REG_STARTUP_LIT, 16'hFFFF);
		write_reg(sled_pkg::REG_STARTUP_DARK, 16'hFFFF);
		send_tick(1'b1, 8'd255);
		for (i = 0; i < 12; i++)
			send_tick(1'($urandom_range(1)), 8'($urandom_range(255)));
		wait_drain();
	endtask

	function automatic logic [15:0] pick_len();
		int r;
		r = $urandom_range(19);
		if (r == 0)
			return 16'd0;
		if (r == 1)
			return 16'($urandom_range(40, 16));
		return 16'($urandom_range(5, 1));
	endfunction

	function automatic logic [7:0] pick_clients();
		int r;
		r = $urandom_range(39);
		if (r == 0)
			return 8'($urandom_range(255));
		if (r < 8)
			return 8'($urandom_range(15));
		if (r < 30)
			return 8'($urandom_range(4, 1));
		return 8'd0;
	endfunction

	// Random timing and random ticks under one idling mix.
	task automatic test_random(input int in_idle, input int out_stall, input int n);
		int i;
		wait_drain();
		write_reg(sled_pkg::REG_ACTIVE_LEVEL, 16'($urandom_range(1)));
		set_timing(pick_len(), pick_len(), pick_len(), pick_len());
		in_idle_pct = in_idle;
		out_stall_pct = out_stall;
		for (i = 0; i < n; i++) begin
			// Let the pipeline run dry once, halfway through the run.
			if (i == n / 2)
				wait_drain();
			send_tick(1'($urandom_range(1)), pick_clients());
		end
		wait_drain();
		in_idle_pct = 0;
		out_stall_pct = 0;
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = sled_pkg::REG_LED_ENABLED;
		cfg_data = 16'd0;
		in_valid = 1'b0;
		link_up = 1'b0;
		num_clients = 8'd0;
		out_ready = 1'b0;
		pattern_reset();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_startup();
		test_blink_groups();
		test_polarity_disable();
		test_random(0, 0, 60);
		test_random(78, 0, 60);
		test_random(0, 78, 60);
		test_random(33, 33, 60);
		test_long_segment();

		wait_drain();
		if (expected_ticks.size() != 0) begin
			$error("%0d results never arrived", expected_ticks.size());
			errors++;
		end
		$display("Sent %0d ticks over %0d blink cycles with %0d register writes.",
			ticks_sent, cycles_begun, reg_writes);
		$display("Checked %0d results across startup, groups, polarity, disable, stalls %s",
			results_seen, "and full-width values.");
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
